// File: rtl/pesw_pkg.sv
// shared types and constants for the polygon edge scan walker
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package pesw_pkg;

  localparam int COORD_BITS      = 12;
  localparam int ERR_BITS        = COORD_BITS + 1;
  localparam int Q_DEPTH_DEFAULT = 2;
  localparam int DIV_CNT_BITS    = $clog2(COORD_BITS + 1);

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0]        ucoord_t;
  typedef logic signed [ERR_BITS-1:0]   err_t;

  typedef struct packed {
    logic   func;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
    logic   skip_first;
    logic   side;
  } cmd_t;

  typedef struct packed {
    coord_t x_out;
    logic   side_out;
    logic   valid_res;
    logic   last;
  } res_t;

  typedef enum logic [1:0] {
    OP_STEP,
    OP_LOAD,
    OP_LOAD_EMPTY
  } op_t;

  // classified command as it waits between front and back
  typedef struct packed {
    op_t     op;
    coord_t  x_start;
    ucoord_t width;
    ucoord_t height;
    logic    dir_neg;
    logic    err_neg;
    logic    skip;
    logic    side;
  } entry_t;

  typedef struct packed {
    logic    start;
    ucoord_t num;
    ucoord_t den;
  } div_req_t;

  typedef struct packed {
    logic    busy;
    logic    done;
    ucoord_t quo;
    ucoord_t rem;
  } div_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SKIP
  } walk_state_t;

  typedef struct packed {
    walk_state_t state;
    logic        q_pop;
  } walk_stat_t;

endpackage

// File: rtl/pesw_front.sv
// front end: classifies incoming commands and queues them for the walker
// depends on pesw_pkg
`timescale 1ns / 1ps

module pesw_front #(
  parameter int DEPTH = pesw_pkg::Q_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  pesw_pkg::cmd_t   cmd,
  output logic             q_valid,
  output pesw_pkg::entry_t q_head,
  input  logic             q_pop
);
  import pesw_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic signed [COORD_BITS:0] abs_dx;
  logic                       dx_neg;
  logic                       dx_zero;
  logic                       h_pos;
  entry_t                     cls;

  // endpoint differences, one bit wider than the coordinates
  always_comb begin
    dx      = {cmd.x_end[COORD_BITS-1], cmd.x_end} - {cmd.x_start[COORD_BITS-1], cmd.x_start};
    dy      = {cmd.y_end[COORD_BITS-1], cmd.y_end} - {cmd.y_start[COORD_BITS-1], cmd.y_start};
    dx_neg  = dx[COORD_BITS];
    dx_zero = (dx == '0);
    abs_dx  = dx_neg ? -dx : dx;
    h_pos   = !dy[COORD_BITS] && (dy != '0);

    cls.x_start = cmd.x_start;
    cls.width   = abs_dx[COORD_BITS-1:0];
    cls.height  = dy[COORD_BITS-1:0];
    cls.dir_neg = dx_neg || dx_zero;
    cls.err_neg = dx_neg;
    cls.skip    = cmd.skip_first;
    cls.side    = cmd.side;
    if (cmd.func == FUNC_STEP) begin
      cls.op = OP_STEP;
    end else if (h_pos) begin
      cls.op = OP_LOAD;
    end else begin
      cls.op = OP_LOAD_EMPTY;
    end
  end

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_head  = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/pesw_div.sv
// restoring divider, one quotient bit per cycle
// depends on pesw_pkg
`timescale 1ns / 1ps

module pesw_div (
  input  logic               clk,
  input  logic               rst,
  input  pesw_pkg::div_req_t req,
  output pesw_pkg::div_rsp_t rsp
);
  import pesw_pkg::*;

  logic                    busy;
  logic                    done;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [COORD_BITS:0]     rem;
  ucoord_t                 quo;
  ucoord_t                 den;

  logic [COORD_BITS:0] shifted;
  logic [COORD_BITS:0] trial;
  logic                q_bit;
  logic [COORD_BITS:0] rem_next;

  always_comb begin
    shifted  = {rem[COORD_BITS-1:0], quo[COORD_BITS-1]};
    trial    = shifted - {1'b0, den};
    q_bit    = !trial[COORD_BITS];
    rem_next = q_bit ? trial : shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_BITS'(COORD_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[COORD_BITS-2:0], q_bit};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem[COORD_BITS-1:0];

endmodule

// File: rtl/pesw_back.sv
// back end: edge walker state, load sequencer and result register
// depends on pesw_pkg; drives pesw_div through the request struct
`timescale 1ns / 1ps

module pesw_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  pesw_pkg::entry_t     q_head,
  output logic                 q_pop,
  output pesw_pkg::div_req_t   div_req,
  input  pesw_pkg::div_rsp_t   div_rsp,
  output logic                 empty,
  input  logic                 pop,
  output pesw_pkg::res_t       res,
  output pesw_pkg::walk_stat_t stat
);
  import pesw_pkg::*;

  walk_state_t state;
  walk_state_t state_next;

  ucoord_t cur_x;
  err_t    err_term;
  ucoord_t edge_height;
  ucoord_t whole_step;
  ucoord_t frac_step;
  logic    step_dir;
  ucoord_t lines_left;
  logic    edge_side;
  logic    err_neg;
  logic    skip;

  logic    out_valid;
  res_t    out_res;

  logic    slot_free;
  logic    do_emit;
  logic    do_start;
  logic    do_clear;
  logic    do_take;
  logic    do_skip;

  err_t    err_sum;
  logic    carry;
  err_t    adv_err;
  ucoord_t delta;
  ucoord_t adv_x;
  logic    lines_zero;

  // one scan-line advance of x and the error term
  always_comb begin
    err_sum = err_term + $signed({1'b0, frac_step});
    carry   = !err_sum[ERR_BITS-1] && (err_sum != '0);
    adv_err = carry ? err_sum - $signed({1'b0, edge_height}) : err_sum;
    delta   = whole_step + ucoord_t'(carry);
    adv_x   = step_dir ? cur_x - delta : cur_x + delta;
  end

  assign lines_zero = (lines_left == '0);
  assign slot_free  = !out_valid || pop;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && q_head.op == OP_LOAD) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = skip ? ST_SKIP : ST_IDLE;
        end
      end
      ST_SKIP: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    do_emit  = 1'b0;
    do_start = 1'b0;
    do_clear = 1'b0;
    do_take  = 1'b0;
    do_skip  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_head.op)
            OP_STEP: begin
              q_pop   = slot_free;
              do_emit = slot_free;
            end
            OP_LOAD: begin
              q_pop    = 1'b1;
              do_start = 1'b1;
            end
            OP_LOAD_EMPTY: begin
              q_pop    = 1'b1;
              do_clear = 1'b1;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      ST_DIV:  do_take = div_rsp.done;
      ST_SKIP: do_skip = 1'b1;
      default: ;
    endcase
  end

  assign div_req.start = do_start;
  assign div_req.num   = q_head.width;
  assign div_req.den   = q_head.height;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cur_x       <= '0;
      err_term    <= '0;
      edge_height <= '0;
      whole_step  <= '0;
      frac_step   <= '0;
      step_dir    <= 1'b0;
      lines_left  <= '0;
      edge_side   <= 1'b0;
      err_neg     <= 1'b0;
      skip        <= 1'b0;
    end else begin
      state <= state_next;
      if (do_emit && !lines_zero) begin
        cur_x      <= adv_x;
        err_term   <= adv_err;
        lines_left <= lines_left - 1'b1;
      end
      if (do_start) begin
        cur_x       <= q_head.x_start;
        edge_side   <= q_head.side;
        edge_height <= q_head.height;
        step_dir    <= q_head.dir_neg;
        lines_left  <= q_head.height;
        err_neg     <= q_head.err_neg;
        skip        <= q_head.skip;
      end
      if (do_take) begin
        whole_step <= div_rsp.quo;
        frac_step  <= div_rsp.rem;
        err_term   <= err_neg ? ERR_BITS'(1) - $signed({1'b0, edge_height}) : '0;
      end
      if (do_skip) begin
        cur_x      <= adv_x;
        err_term   <= adv_err;
        lines_left <= lines_left - 1'b1;
      end
      if (do_clear) begin
        cur_x       <= q_head.x_start;
        edge_side   <= q_head.side;
        err_term    <= '0;
        edge_height <= '0;
        whole_step  <= '0;
        frac_step   <= '0;
        step_dir    <= 1'b0;
        lines_left  <= '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      out_res.x_out     <= lines_zero ? '0 : $signed(cur_x);
      out_res.side_out  <= edge_side;
      out_res.valid_res <= !lines_zero;
      out_res.last      <= (lines_left == ucoord_t'(1));
    end
  end

  assign empty      = !out_valid;
  assign res        = out_res;
  assign stat.state = state;
  assign stat.q_pop = q_pop;

endmodule

// File: rtl/polygon_edge_scan_walker_core.sv
// top level of the polygon edge scan walker
// depends on pesw_pkg, pesw_front, pesw_div and pesw_back
`timescale 1ns / 1ps

// usage
//  - commands enter through a queue port: cmd is taken when push is high and full is low
//  - func load brings the endpoints, side and skip flag of a new edge; it gives no result
//  - func step gives one result: the x of the current scan line, or valid_res low once
//    the edge is used up (also after reset, or after a load with no height)
//  - results leave through a queue port: res holds while empty is low, a pop takes it
//  - a step transaction accepted into an idle block goes through the queue slot and then the
//    result register to res; steps then run at one per cycle as long as results are popped
//  - a load keeps the walker busy while the one-bit-a-cycle divider forms the whole and
//    remainder steps, and for one more scan-line advance with skip_first
//  - a small command queue lets new transactions be pushed while the walker divides
//    or while the result waits; full rises when it holds QUEUE_DEPTH commands
//  - when the receiver stalls, the result register holds and steps wait in the queue
//  - synchronous reset empties both sides and zeroes the walker state; no clearing pass
module polygon_edge_scan_walker_core #(
  parameter int QUEUE_DEPTH = pesw_pkg::Q_DEPTH_DEFAULT  // 2 or more
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  pesw_pkg::cmd_t cmd,
  output logic           empty,
  input  logic           pop,
  output pesw_pkg::res_t res
);
  import pesw_pkg::*;

  // front to back queue head
  logic       q_valid;
  entry_t     q_head;
  logic       q_pop;

  // divider handshake
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  // walker status, watched by the checks below
  walk_stat_t stat;

  pesw_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .cmd    (cmd),
    .q_valid(q_valid),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  pesw_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  pesw_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_head (q_head),
    .q_pop  (q_pop),
    .div_req(div_req),
    .div_rsp(div_rsp),
    .empty  (empty),
    .pop    (pop),
    .res    (res),
    .stat   (stat)
  );

  // the divider only runs while the walker waits on it
  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    (div_rsp.busy || div_rsp.done) |-> (stat.state == ST_DIV))
    else $error("divider active outside the divide state");

  // no command is taken from the queue during a divide
  a_no_pop_in_div: assert property (@(posedge clk) disable iff (rst)
    (stat.state == ST_DIV) |-> !stat.q_pop)
    else $error("queue popped while dividing");

  // after an accepted transaction the queue shows a valid head next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> q_valid)
    else $error("pushed transaction missing from queue");

  // a last-line flag only comes with a real scan line
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    (!empty && res.last) |-> res.valid_res)
    else $error("last flag on an exhausted result");

endmodule
